// ===== hdl/slfr_pkg.sv =====
// Shared types, constants and the frame classifier for the sync-length frame receiver.
package slfr_pkg;

  localparam int BYTE_W   = 8;
  localparam int OFFSET_W = 17;
  localparam int LEN_W    = 16;
  localparam int TYPE_W   = 16;
  localparam int CLASS_W  = 3;
  localparam int IDX_W    = 8;
  localparam int CFG_W    = 16;

  localparam int OUT_FIELDS_W = BYTE_W + OFFSET_W + LEN_W + TYPE_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  localparam logic [IDX_W-1:0] REG_MAX_LENGTH   = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_IGNORED_TYPE = IDX_W'(1);

  localparam logic [LEN_W-1:0]  MAX_LENGTH_RST   = 16'd1000;
  localparam logic [TYPE_W-1:0] IGNORED_TYPE_RST = 16'h0090;

  localparam logic [OFFSET_W-1:0] FRAME_EXTRA    = 17'd22;
  localparam logic [OFFSET_W-1:0] OFF_LEN_LOW    = 17'd4;
  localparam logic [OFFSET_W-1:0] OFF_LEN_HIGH   = 17'd5;
  localparam logic [OFFSET_W-1:0] OFF_BODY_START = 17'd6;
  localparam logic [OFFSET_W-1:0] OFF_TYPE_LO    = 17'd18;
  localparam logic [OFFSET_W-1:0] OFF_TYPE_HI    = 17'd19;
  localparam logic [OFFSET_W-1:0] OFF_SYNC_LAST  = 17'd3;

  localparam logic [BYTE_W-1:0] SYNC_WORD [4] = '{8'h12, 8'h34, 8'h56, 8'h79};

  localparam logic [TYPE_W-1:0] TYPE_A = 16'h0280;
  localparam logic [TYPE_W-1:0] TYPE_B = 16'h0281;
  localparam logic [TYPE_W-1:0] TYPE_C = 16'h0282;
  localparam logic [TYPE_W-1:0] TYPE_D = 16'h0283;
  localparam logic [TYPE_W-1:0] TYPE_E = 16'h0500;

  localparam logic [CLASS_W-1:0] CLS_EMPTY   = 3'd0;
  localparam logic [CLASS_W-1:0] CLS_IGNORED = 3'd1;
  localparam logic [CLASS_W-1:0] CLS_TYPE_A  = 3'd2;
  localparam logic [CLASS_W-1:0] CLS_TYPE_B  = 3'd3;
  localparam logic [CLASS_W-1:0] CLS_TYPE_C  = 3'd4;
  localparam logic [CLASS_W-1:0] CLS_TYPE_D  = 3'd5;
  localparam logic [CLASS_W-1:0] CLS_TYPE_E  = 3'd6;
  localparam logic [CLASS_W-1:0] CLS_UNKNOWN = 3'd7;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LEN,
    PH_BODY
  } phase_t;

  typedef struct packed {
    logic                valid;
    logic [BYTE_W-1:0]   data_byte;
    logic [OFFSET_W-1:0] byte_offset;
    logic                frame_end;
    logic [LEN_W-1:0]    payload_length;
    logic [TYPE_W-1:0]   type_word;
    logic [CLASS_W-1:0]  frame_class;
  } result_t;

  function automatic logic [CLASS_W-1:0] classify(
    input logic [LEN_W-1:0]  len,
    input logic [TYPE_W-1:0] type_word,
    input logic [TYPE_W-1:0] ignored
  );
    logic [CLASS_W-1:0] cls;
    if (len == '0) begin
      cls = CLS_EMPTY;
    end else if (type_word == ignored) begin
      cls = CLS_IGNORED;
    end else begin
      case (type_word)
        TYPE_A:  cls = CLS_TYPE_A;
        TYPE_B:  cls = CLS_TYPE_B;
        TYPE_C:  cls = CLS_TYPE_C;
        TYPE_D:  cls = CLS_TYPE_D;
        TYPE_E:  cls = CLS_TYPE_E;
        default: cls = CLS_UNKNOWN;
      endcase
    end
    return cls;
  endfunction

endpackage

// ===== hdl/sync_length_frame_receiver.sv =====
// Top level: input register, frame parser, result register and configuration registers.
//
// Receives one byte per transfer and sustains one byte per clock while the
// output is not stalled; a byte passes through an input register and then
// a result register, which holds its result until the output takes it.
// The hunt looks for sync 12 34 56 79, then a little-endian length;
// lengths above max_length resume the hunt. Each frame byte from offset six
// on is delivered with its offset, and the last one (offset length+21)
// carries tlast, the length, the type word from offsets 18-19 and the class
// in tuser. Configuration writes are always accepted; index 0 is max_length,
// index 1 is ignored_type, other indexes are dropped.
module sync_length_frame_receiver (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] rx_byte
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [slfr_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [7:0] data_byte, [24:8] byte_offset,
                                                        // [40:25] payload_length,
                                                        // [56:41] type_word, [63:57] zero
  output logic                              out_tlast,
  output logic [slfr_pkg::CLASS_W-1:0]      out_tuser,  // [2:0] frame_class
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [slfr_pkg::IDX_W-1:0]        cfg_index,
  input  logic [slfr_pkg::CFG_W-1:0]        cfg_data
);

  logic                          s1_valid_r;
  logic [slfr_pkg::BYTE_W-1:0]   s1_byte_r;
  logic                          out_valid_r;
  slfr_pkg::result_t             out_r;
  slfr_pkg::result_t             res;
  logic [slfr_pkg::LEN_W-1:0]    max_length_r;
  logic [slfr_pkg::TYPE_W-1:0]   ignored_type_r;
  logic                          out_free;
  logic                          step;

  assign out_free  = !out_valid_r || out_tready;
  assign step      = s1_valid_r && (!res.valid || out_free);
  assign in_tready = !s1_valid_r || step;
  assign cfg_ready = 1'b1;

  slfr_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .rx_byte      (s1_byte_r),
    .max_length   (max_length_r),
    .ignored_type (ignored_type_r),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r   <= slfr_pkg::MAX_LENGTH_RST;
      ignored_type_r <= slfr_pkg::IGNORED_TYPE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        slfr_pkg::REG_MAX_LENGTH:   max_length_r   <= cfg_data;
        slfr_pkg::REG_IGNORED_TYPE: ignored_type_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (step) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{slfr_pkg::OUT_PAD_W{1'b0}}, out_r.type_word, out_r.payload_length,
                       out_r.byte_offset, out_r.data_byte};
  assign out_tlast  = out_r.frame_end;
  assign out_tuser  = out_r.frame_class;

endmodule

// ===== hdl/slfr_parser.sv =====
// Frame state machine: sync hunt, length capture, body offsets and end-of-frame class.
module slfr_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [slfr_pkg::BYTE_W-1:0]   rx_byte,
  input  logic [slfr_pkg::LEN_W-1:0]    max_length,
  input  logic [slfr_pkg::TYPE_W-1:0]   ignored_type,
  output slfr_pkg::result_t             res
);

  slfr_pkg::phase_t                phase_r, phase_nxt;
  logic [slfr_pkg::OFFSET_W-1:0]   pos_r, pos_nxt;
  logic [slfr_pkg::BYTE_W-1:0]     len_low_r, len_low_nxt;
  logic [slfr_pkg::LEN_W-1:0]      length_r, length_nxt;
  logic [slfr_pkg::OFFSET_W-1:0]   total_r, total_nxt;
  logic [slfr_pkg::TYPE_W-1:0]     type_r, type_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= slfr_pkg::PH_HUNT;
      pos_r     <= '0;
      len_low_r <= '0;
      length_r  <= '0;
      total_r   <= '0;
      type_r    <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      len_low_r <= len_low_nxt;
      length_r  <= length_nxt;
      total_r   <= total_nxt;
      type_r    <= type_nxt;
    end
  end

  always_comb begin
    logic [slfr_pkg::LEN_W-1:0]    len;
    logic [slfr_pkg::OFFSET_W-1:0] pos_inc;
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    len_low_nxt = len_low_r;
    length_nxt  = length_r;
    total_nxt   = total_r;
    type_nxt    = type_r;
    res         = '0;
    len         = {rx_byte, len_low_r};
    pos_inc     = pos_r + 17'd1;
    case (phase_r)
      slfr_pkg::PH_HUNT: begin
        if (rx_byte == slfr_pkg::SYNC_WORD[pos_r[1:0]]) begin
          pos_nxt = pos_inc;
          if (pos_r == slfr_pkg::OFF_SYNC_LAST) begin
            phase_nxt = slfr_pkg::PH_LEN;
          end
        end else begin
          pos_nxt = '0;
        end
      end
      slfr_pkg::PH_LEN: begin
        if (pos_r == slfr_pkg::OFF_LEN_LOW) begin
          len_low_nxt = rx_byte;
          pos_nxt     = slfr_pkg::OFF_LEN_HIGH;
        end else if (len > max_length) begin
          phase_nxt = slfr_pkg::PH_HUNT;
          pos_nxt   = '0;
        end else begin
          length_nxt = len;
          total_nxt  = {1'b0, len} + slfr_pkg::FRAME_EXTRA;
          phase_nxt  = slfr_pkg::PH_BODY;
          pos_nxt    = slfr_pkg::OFF_BODY_START;
        end
      end
      slfr_pkg::PH_BODY: begin
        if (pos_r == slfr_pkg::OFF_TYPE_LO) begin
          type_nxt = {type_r[15:8], rx_byte};
        end else if (pos_r == slfr_pkg::OFF_TYPE_HI) begin
          type_nxt = {rx_byte, type_r[7:0]};
        end
        res.valid       = 1'b1;
        res.data_byte   = rx_byte;
        res.byte_offset = pos_r;
        if (pos_inc == total_r) begin
          res.frame_end      = 1'b1;
          res.payload_length = length_r;
          res.type_word      = type_nxt;
          res.frame_class    = slfr_pkg::classify(length_r, type_nxt, ignored_type);
          phase_nxt          = slfr_pkg::PH_HUNT;
          pos_nxt            = '0;
        end else begin
          pos_nxt = pos_inc;
        end
      end
      default: begin
        phase_nxt = slfr_pkg::PH_HUNT;
        if (rx_byte == slfr_pkg::SYNC_WORD[0]) begin
          pos_nxt = 17'd1;
        end else begin
          pos_nxt = '0;
        end
      end
    endcase
  end

endmodule

// ===== hdl/slfr_checker.sv =====
// Port-level checker for the sync-length frame receiver, bound to the top level.
module slfr_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [slfr_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                              out_tlast,
  input  logic [slfr_pkg::CLASS_W-1:0]      out_tuser
);

  a_mid_frame_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[56:25] == '0 && out_tuser == slfr_pkg::CLS_EMPTY)
    else $error("frame summary fields set on a byte that is not the last");

  a_offset_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[24:8] >= slfr_pkg::OFF_BODY_START)
    else $error("byte offset below the first body byte");

  a_empty_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |->
      (out_tuser == slfr_pkg::CLS_EMPTY) == (out_tdata[40:25] == '0))
    else $error("empty class does not match a zero payload length");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled transfer changed");

endmodule

bind sync_length_frame_receiver slfr_checker u_slfr_checker (.*);

// ===== verif/tb.sv =====
// Testbench for the sync-length frame receiver: byte stream stimulus, frame predictor, scoreboard.
`timescale 1ns / 100ps

localparam logic [31:0] SYNC_PATTERN   = 32'h7956_3412;
localparam int          SYNC_LEN       = 4;
localparam logic [16:0] FRAME_OVERHEAD = 17'd22;
localparam logic [16:0] LEN_LO_POS     = 17'd4;
localparam logic [16:0] BODY_START     = 17'd6;
localparam logic [16:0] TYPE_LO_POS    = 17'd18;
localparam logic [16:0] TYPE_HI_POS    = 17'd19;
localparam logic [15:0] KNOWN_TYPE_A   = 16'h0280;
localparam logic [15:0] KNOWN_TYPE_B   = 16'h0281;
localparam logic [15:0] KNOWN_TYPE_C   = 16'h0282;
localparam logic [15:0] KNOWN_TYPE_D   = 16'h0283;
localparam logic [15:0] KNOWN_TYPE_E   = 16'h0500;
localparam logic [15:0] MAX_LEN_RESET  = 16'd1000;
localparam logic [15:0] IGNORED_RESET  = 16'h0090;
localparam logic [7:0]  REG_SPARE_LOW  = 8'd2;
localparam logic [7:0]  REG_SPARE_HIGH = 8'hFF;
localparam int          OFFSET_LSB     = 8;
localparam int          LENGTH_LSB     = 25;
localparam int          TYPE_LSB       = 41;
localparam int          PAD_LSB        = 57;

class frame_scoreboard;
  typedef struct {
    logic [7:0]  data_byte;
    logic [16:0] byte_offset;
    logic        frame_end;
    logic [15:0] payload_length;
    logic [15:0] type_word;
    logic [2:0]  frame_class;
  } beat_t;

  slfr_pkg::phase_t phase;
  logic [16:0]      position;
  logic [16:0]      frame_total;
  logic [7:0]       length_low;
  logic [15:0]      captured_type;
  logic [15:0]      max_length;
  logic [15:0]      ignored_type;
  beat_t            pending[$];
  int               errors;
  int               beats_checked;
  int               frames_closed;
  int               class_hits[8];

  function new();
    phase         = slfr_pkg::PH_HUNT;
    position      = '0;
    frame_total   = '0;
    length_low    = '0;
    captured_type = '0;
    max_length    = MAX_LEN_RESET;
    ignored_type  = IGNORED_RESET;
    errors        = 0;
    beats_checked = 0;
    frames_closed = 0;
    foreach (class_hits[i]) class_hits[i] = 0;
  endfunction

  function void set_register(logic [7:0] idx, logic [15:0] value);
    case (idx)
      slfr_pkg::REG_MAX_LENGTH:   max_length = value;
      slfr_pkg::REG_IGNORED_TYPE: ignored_type = value;
      default: ;
    endcase
  endfunction

  function void note_byte(logic [7:0] b);
    beat_t       beat;
    logic [16:0] next_pos;
    logic [15:0] len;
    int          k;
    case (phase)
      slfr_pkg::PH_LEN: begin
        if (position == LEN_LO_POS) begin
          length_low = b;
          position   = LEN_LO_POS + 17'd1;
        end else begin
          len = {b, length_low};
          if (len > max_length) begin
            phase    = slfr_pkg::PH_HUNT;
            position = '0;
          end else begin
            frame_total = 17'(len) + FRAME_OVERHEAD;
            phase       = slfr_pkg::PH_BODY;
            position    = BODY_START;
          end
        end
      end
      slfr_pkg::PH_BODY: begin
        if (position == TYPE_LO_POS) captured_type[7:0] = b;
        else if (position == TYPE_HI_POS) captured_type[15:8] = b;
        next_pos            = position + 17'd1;
        beat.data_byte      = b;
        beat.byte_offset    = position;
        beat.frame_end      = 1'b0;
        beat.payload_length = '0;
        beat.type_word      = '0;
        beat.frame_class    = slfr_pkg::CLS_EMPTY;
        if (next_pos == frame_total) begin
          len                 = 16'(frame_total - FRAME_OVERHEAD);
          beat.frame_end      = 1'b1;
          beat.payload_length = len;
          beat.type_word      = captured_type;
          if (len == '0) beat.frame_class = slfr_pkg::CLS_EMPTY;
          else if (captured_type == ignored_type) beat.frame_class = slfr_pkg::CLS_IGNORED;
          else begin
            case (captured_type)
              KNOWN_TYPE_A: beat.frame_class = slfr_pkg::CLS_TYPE_A;
              KNOWN_TYPE_B: beat.frame_class = slfr_pkg::CLS_TYPE_B;
              KNOWN_TYPE_C: beat.frame_class = slfr_pkg::CLS_TYPE_C;
              KNOWN_TYPE_D: beat.frame_class = slfr_pkg::CLS_TYPE_D;
              KNOWN_TYPE_E: beat.frame_class = slfr_pkg::CLS_TYPE_E;
              default:      beat.frame_class = slfr_pkg::CLS_UNKNOWN;
            endcase
          end
          phase    = slfr_pkg::PH_HUNT;
          position = '0;
        end else begin
          position = next_pos;
        end
        pending.push_back(beat);
      end
      default: begin
        if (phase != slfr_pkg::PH_HUNT || position >= SYNC_LEN) begin
          phase    = slfr_pkg::PH_HUNT;
          position = '0;
        end
        k = int'(position[1:0]);
        if (b == SYNC_PATTERN[8*k +: 8]) begin
          position = position + 17'd1;
          if (position == SYNC_LEN) phase = slfr_pkg::PH_LEN;
        end else begin
          position = '0;
        end
      end
    endcase
  endfunction

  task report(string what);
    errors++;
    if (errors <= 40) $display("tb: MISMATCH %s", what);
  endtask

  task check_result(logic [slfr_pkg::OUT_TDATA_W-1:0] tdata, logic tlast,
                    logic [slfr_pkg::CLASS_W-1:0] tuser);
    beat_t want;
    if (pending.size() == 0) begin
      report($sformatf("unexpected transfer, tdata %h", tdata));
      return;
    end
    want = pending.pop_front();
    beats_checked++;
    if (tdata[7:0] !== want.data_byte)
      report($sformatf("offset %0d: data_byte %h, want %h", want.byte_offset, tdata[7:0],
                       want.data_byte));
    if (tdata[OFFSET_LSB +: 17] !== want.byte_offset)
      report($sformatf("byte_offset %0d, want %0d", tdata[OFFSET_LSB +: 17], want.byte_offset));
    if (tlast !== want.frame_end)
      report($sformatf("offset %0d: tlast %b, want %b", want.byte_offset, tlast, want.frame_end));
    if (tdata[LENGTH_LSB +: 16] !== want.payload_length)
      report($sformatf("offset %0d: payload_length %h, want %h", want.byte_offset,
                       tdata[LENGTH_LSB +: 16], want.payload_length));
    if (tdata[TYPE_LSB +: 16] !== want.type_word)
      report($sformatf("offset %0d: type_word %h, want %h", want.byte_offset,
                       tdata[TYPE_LSB +: 16], want.type_word));
    if (tdata[slfr_pkg::OUT_TDATA_W-1:PAD_LSB] !== '0)
      report($sformatf("offset %0d: nonzero padding in tdata %h", want.byte_offset, tdata));
    if (tuser !== want.frame_class)
      report($sformatf("offset %0d: frame_class %0d, want %0d", want.byte_offset, tuser,
                       want.frame_class));
    if (want.frame_end) begin
      frames_closed++;
      class_hits[want.frame_class]++;
    end
  endtask
endclass

module tb;
  localparam int PHASE_BYTES  = 260;
  localparam int LONG_HOLD    = 400;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 6;

  logic                             clk;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [7:0]                       in_tdata   = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [slfr_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             out_tlast;
  logic [slfr_pkg::CLASS_W-1:0]     out_tuser;
  logic                             cfg_valid  = 1'b0;
  logic                             cfg_ready;
  logic [slfr_pkg::IDX_W-1:0]       cfg_index  = '0;
  logic [slfr_pkg::CFG_W-1:0]       cfg_data   = '0;

  frame_scoreboard sb;
  bit              sender_steady = 1'b0;
  int              holds_asked   = 0;
  int              bytes_sent    = 0;

  sync_length_frame_receiver dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] pick_length();
    int r;
    int cap;
    r   = $urandom_range(0, 99);
    cap = (sb.max_length < 16'd48) ? int'(sb.max_length) : 48;
    if (r < 10) return '0;
    if (r < 20) return 16'(cap);
    return 16'($urandom_range(0, cap));
  endfunction

  function automatic logic [15:0] pick_type();
    case ($urandom_range(0, 7))
      0:       return sb.ignored_type;
      1:       return KNOWN_TYPE_A;
      2:       return KNOWN_TYPE_B;
      3:       return KNOWN_TYPE_C;
      4:       return KNOWN_TYPE_D;
      5:       return KNOWN_TYPE_E;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] value);
    int gap;
    gap = sender_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(value);
    bytes_sent++;
  endtask

  task automatic send_sync(input int count);
    for (int i = 0; i < count; i++) send_byte(SYNC_PATTERN[8*i +: 8]);
  endtask

  task automatic send_frame(input logic [15:0] len, input logic [15:0] type_w);
    int         total;
    logic [7:0] b;
    total = int'(len) + int'(FRAME_OVERHEAD);
    send_sync(SYNC_LEN);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    for (int off = int'(BODY_START); off < total; off++) begin
      if (off == int'(TYPE_LO_POS)) b = type_w[7:0];
      else if (off == int'(TYPE_HI_POS)) b = type_w[15:8];
      else b = 8'($urandom);
      send_byte(b);
    end
  endtask

  task automatic send_random_chunk();
    int pick;
    int over;
    int n;
    pick          = $urandom_range(0, 99);
    sender_steady = ($urandom_range(0, 4) == 0);
    if (pick < 70) begin
      send_frame(pick_length(), pick_type());
    end else if (pick < 80 && sb.max_length != 16'hFFFF) begin
      over = int'(sb.max_length) + 1 + $urandom_range(0, 300);
      if (over > 65535) over = 65535;
      send_sync(SYNC_LEN);
      send_byte(over[7:0]);
      send_byte(over[15:8]);
    end else if (pick < 90) begin
      n = $urandom_range(1, 6);
      repeat (n) send_byte(8'($urandom));
    end else begin
      send_sync($urandom_range(1, 3));
      send_byte(8'($urandom));
    end
  endtask

  // hold input, let in-flight bytes land
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] max_len, input logic [15:0] ign_type,
                           input logic [7:0] spare_idx);
    logic [7:0]  idx [3];
    logic [15:0] val [3];
    idx[0] = slfr_pkg::REG_MAX_LENGTH;
    val[0] = max_len;
    idx[1] = slfr_pkg::REG_IGNORED_TYPE;
    val[1] = ign_type;
    idx[2] = spare_idx;
    val[2] = 16'($urandom);
    cfg_valid <= 1'b1;
    for (int i = 0; i < 3; i++) begin
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      sb.set_register(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int stall;
    int holds_done;
    bit steady;
    stall      = 0;
    holds_done = 0;
    steady     = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast, out_tuser);
      if ($urandom_range(0, 199) == 0) steady = !steady;
      if (holds_done < holds_asked) begin
        holds_done++;
        stall = LONG_HOLD;
      end else if (stall == 0 && !steady) begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    wait (rst_n === 1'b1);
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("tb: watchdog, no transfer for %0d cycles", STALL_LIMIT);
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    int start;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_byte(8'h00);
    send_byte(8'hFF);
    send_sync(2);
    send_sync(SYNC_LEN);
    send_sync(1);
    send_sync(SYNC_LEN);
    send_sync(SYNC_LEN);
    send_byte(8'(MAX_LEN_RESET + 16'd1));
    send_byte(8'((MAX_LEN_RESET + 16'd1) >> 8));
    send_frame(16'd0, KNOWN_TYPE_A);
    send_frame(16'd1, IGNORED_RESET);

    for (int ph = 0; ph < 5; ph++) begin
      drain_results();
      case (ph)
        0:       configure(16'hFFFF, KNOWN_TYPE_C, REG_SPARE_LOW);
        1:       configure(16'd0, 16'd0, REG_SPARE_HIGH);
        2:       configure(16'd40, 16'hFFFF, REG_SPARE_LOW);
        3:       configure(16'($urandom_range(10, 60)), pick_type(), REG_SPARE_HIGH);
        default: configure(MAX_LEN_RESET, IGNORED_RESET, REG_SPARE_LOW);
      endcase
      if (ph == 0) begin
        send_frame(16'd260, KNOWN_TYPE_E);
        holds_asked++;
        sender_steady = 1'b1;
        send_frame(16'd48, KNOWN_TYPE_D);
        sender_steady = 1'b0;
        drain_results();
      end
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) send_random_chunk();
    end
    drain_results();

    $display("tb: %0d bytes in, %0d result transfers checked, %0d frames closed",
             bytes_sent, sb.beats_checked, sb.frames_closed);
    $display("tb: frames per class 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
             sb.class_hits[0], sb.class_hits[1], sb.class_hits[2], sb.class_hits[3],
             sb.class_hits[4], sb.class_hits[5], sb.class_hits[6], sb.class_hits[7]);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
